@@ sv/flba_pkg.sv @@
// flba_pkg: shared types and constants for the free-list block allocator
// depends on nothing; used by free_list_block_allocator
package flba_pkg;

  // default pool size in blocks
  localparam int unsigned NUM_BLOCKS_DEF = 1024;

  // fixed field widths of the request and response transactions
  localparam int unsigned BLK_W   = 10;
  localparam int unsigned FREE_W  = 11;
  localparam int unsigned TOTAL_W = 32;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // control states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

@@ sv/flba_ram.sv @@
// flba_ram: generic single-clock ram, one write and one read port
// read data is registered; no package dependency
module flba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/free_list_block_allocator.sv @@
// free_list_block_allocator: lifo free list of equal blocks, link words in flba_ram
// result: registered in the output register, or first parked in a hold slot while
//   the output is stalled; an allocate that pops the freed chain waits in the link
//   read state (head link is read from the ram, the next request waits for it)
// reset (rst_n, synchronous): no freed blocks, all blocks fresh, counts at pool size,
//   allocation total zero; the link ram is not cleared
module free_list_block_allocator #(
  parameter int unsigned NUM_BLOCKS = flba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [flba_pkg::BLK_W-1:0]   in_block_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [flba_pkg::BLK_W-1:0]   out_block_out,
  output logic                         out_empty_res,
  output logic [flba_pkg::FREE_W-1:0]  out_free_blocks,
  output logic [flba_pkg::TOTAL_W-1:0] out_total_allocs
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LNK_W = IDX_W + 1;

  flba_pkg::state_t state_r, state_nxt;

  logic                         head_ok_r, head_ok_nxt;
  logic [IDX_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             fresh_r, fresh_nxt;
  logic [CNT_W-1:0]             free_r, free_nxt;
  logic [flba_pkg::TOTAL_W-1:0] total_r, total_nxt;

  logic                         out_vld_r, out_vld_nxt;
  logic [flba_pkg::BLK_W-1:0]   out_blk_r, out_blk_nxt;
  logic                         out_emp_r, out_emp_nxt;
  logic [flba_pkg::FREE_W-1:0]  out_free_r, out_free_nxt;
  logic [flba_pkg::TOTAL_W-1:0] out_tot_r, out_tot_nxt;

  logic                         hold_vld_r, hold_vld_nxt;
  logic [flba_pkg::BLK_W-1:0]   hold_blk_r, hold_blk_nxt;
  logic                         hold_emp_r, hold_emp_nxt;
  logic [flba_pkg::FREE_W-1:0]  hold_free_r, hold_free_nxt;
  logic [flba_pkg::TOTAL_W-1:0] hold_tot_r, hold_tot_nxt;

  logic             in_fire, is_alloc, blk_ok;
  logic             do_pop, do_fresh, do_empty, do_push;
  logic [31:0]      blk_ext;
  logic [IDX_W-1:0] blk_idx;
  logic [CNT_W-1:0] fresh_dec;
  logic [IDX_W-1:0] res_given;
  logic [31:0]      given_ext, free_ext;
  logic             out_slot_ok;

  logic             ram_we;
  logic [LNK_W-1:0] ram_wdata, ram_rdata;

  // link words: {link valid, next index}
  flba_ram #(
    .WIDTH (LNK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (blk_idx),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // request decode
  always_comb begin
    in_fire   = in_valid && in_ready;
    is_alloc  = (in_func == flba_pkg::FUNC_ALLOC);
    blk_ext   = {{(32 - flba_pkg::BLK_W){1'b0}}, in_block_in};
    blk_ok    = (blk_ext < 32'(NUM_BLOCKS));
    blk_idx   = blk_ext[IDX_W-1:0];
    do_pop    = in_fire && is_alloc && head_ok_r;
    do_fresh  = in_fire && is_alloc && !head_ok_r && (fresh_r != '0);
    do_empty  = in_fire && is_alloc && !head_ok_r && (fresh_r == '0);
    do_push   = in_fire && !is_alloc && blk_ok;
    fresh_dec = fresh_r - CNT_W'(1);
    ram_we    = do_push;
    ram_wdata = {head_ok_r, head_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      flba_pkg::ST_IDLE: begin
        if (do_pop) begin
          state_nxt = flba_pkg::ST_READ;
        end
      end
      flba_pkg::ST_READ: begin
        state_nxt = flba_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = flba_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs: requests are taken only when idle and nothing is parked
  always_comb begin
    case (state_r)
      flba_pkg::ST_IDLE: in_ready = !hold_vld_r;
      flba_pkg::ST_READ: in_ready = 1'b0;
      default:           in_ready = 1'b0;
    endcase
  end

  // free list head and counters
  always_comb begin
    head_ok_nxt = head_ok_r;
    head_nxt    = head_r;
    fresh_nxt   = fresh_r;
    free_nxt    = free_r;
    total_nxt   = total_r;
    res_given   = '0;
    if (state_r == flba_pkg::ST_READ) begin
      // link of the popped block becomes the new head
      head_ok_nxt = ram_rdata[IDX_W];
      head_nxt    = ram_rdata[IDX_W-1:0];
    end
    if (do_pop) begin
      res_given = head_r;
    end
    if (do_fresh) begin
      fresh_nxt = fresh_dec;
      res_given = fresh_dec[IDX_W-1:0];
    end
    if (do_pop || do_fresh) begin
      if (free_r != '0) begin
        free_nxt = free_r - CNT_W'(1);
      end
      total_nxt = total_r + 32'd1;
    end
    if (do_push) begin
      head_ok_nxt = 1'b1;
      head_nxt    = blk_idx;
      if (free_r < CNT_W'(NUM_BLOCKS)) begin
        free_nxt = free_r + CNT_W'(1);
      end
    end
  end

  // result transaction: output register plus one parking slot
  always_comb begin
    given_ext     = {{(32 - IDX_W){1'b0}}, res_given};
    free_ext      = {{(32 - CNT_W){1'b0}}, free_nxt};
    out_slot_ok   = !out_vld_r || out_ready;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_blk_nxt   = out_blk_r;
    out_emp_nxt   = out_emp_r;
    out_free_nxt  = out_free_r;
    out_tot_nxt   = out_tot_r;
    hold_vld_nxt  = hold_vld_r;
    hold_blk_nxt  = given_ext[flba_pkg::BLK_W-1:0];
    hold_emp_nxt  = do_empty;
    hold_free_nxt = free_ext[flba_pkg::FREE_W-1:0];
    hold_tot_nxt  = total_nxt;
    if (hold_vld_r) begin
      hold_blk_nxt  = hold_blk_r;
      hold_emp_nxt  = hold_emp_r;
      hold_free_nxt = hold_free_r;
      hold_tot_nxt  = hold_tot_r;
      if (out_slot_ok) begin
        out_vld_nxt  = 1'b1;
        out_blk_nxt  = hold_blk_r;
        out_emp_nxt  = hold_emp_r;
        out_free_nxt = hold_free_r;
        out_tot_nxt  = hold_tot_r;
        hold_vld_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (out_slot_ok) begin
        out_vld_nxt  = 1'b1;
        out_blk_nxt  = given_ext[flba_pkg::BLK_W-1:0];
        out_emp_nxt  = do_empty;
        out_free_nxt = free_ext[flba_pkg::FREE_W-1:0];
        out_tot_nxt  = total_nxt;
      end else begin
        hold_vld_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= flba_pkg::ST_IDLE;
      head_ok_r  <= 1'b0;
      fresh_r    <= CNT_W'(NUM_BLOCKS);
      free_r     <= CNT_W'(NUM_BLOCKS);
      total_r    <= '0;
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_ok_r  <= head_ok_nxt;
      fresh_r    <= fresh_nxt;
      free_r     <= free_nxt;
      total_r    <= total_nxt;
      out_vld_r  <= out_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_r      <= head_nxt;
    out_blk_r   <= out_blk_nxt;
    out_emp_r   <= out_emp_nxt;
    out_free_r  <= out_free_nxt;
    out_tot_r   <= out_tot_nxt;
    hold_blk_r  <= hold_blk_nxt;
    hold_emp_r  <= hold_emp_nxt;
    hold_free_r <= hold_free_nxt;
    hold_tot_r  <= hold_tot_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_block_out    = out_blk_r;
  assign out_empty_res    = out_emp_r;
  assign out_free_blocks  = out_free_r;
  assign out_total_allocs = out_tot_r;

`ifndef SYNTHESIS
  // free count never passes the pool size
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CNT_W'(NUM_BLOCKS))
    else $error("free count above pool size");

  // popping the freed chain waits for the link read
  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_alloc && head_ok_r) |=> (state_r == flba_pkg::ST_READ))
    else $error("pop did not enter link read");

  // a parked result implies the output register is occupied
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> out_vld_r)
    else $error("parked result with empty output register");

  // a freed block becomes the new head
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> (head_ok_r && head_r == $past(blk_idx)))
    else $error("free did not update head");
`endif

endmodule
